FILE: rtl/mtf_pkg.sv
// shared types for the move-to-front encoder cell chain
`timescale 1ns / 1ps
package mtf_pkg;

  localparam int SYM_W  = 8;
  localparam int RANK_W = 8;

  // one word travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  symbol;
    logic [SYM_W-1:0]  carry;
    logic              found;
    logic [RANK_W-1:0] rank;
    logic              last;
  } mtf_token_t;

endpackage

FILE: rtl/mtf_ifs.sv
// handshake interfaces for the symbol input and rank output channels
`timescale 1ns / 1ps
interface mtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface mtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rank;
  logic       last_out;

  modport source (output valid, output rank, output last_out, input ready);
  modport sink (input valid, input rank, input last_out, output ready);
endinterface

FILE: rtl/mtf_cell.sv
// one list position: holds an entry, compares and swaps with the passing word
`timescale 1ns / 1ps
module mtf_cell
  import mtf_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  mtf_token_t tok_in,
  output mtf_token_t tok_out
);

  localparam logic [SYM_W-1:0]  IDENT_VAL = SYM_W'(CELL_INDEX);
  localparam logic [RANK_W-1:0] POS       = RANK_W'(CELL_INDEX);

  logic [SYM_W-1:0] entry;
  logic             hit;
  mtf_token_t       tok_next;

  assign hit = !tok_in.found && (entry == tok_in.symbol);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found) begin
      // displaced entry moves one place back
      tok_next.carry = entry;
    end
    tok_next.found = tok_in.found | hit;
    if (hit) begin
      tok_next.rank = POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= IDENT_VAL;
    end else if (adv && tok_in.valid) begin
      if (tok_in.last) begin
        entry <= IDENT_VAL;
      end else if (!tok_in.found) begin
        entry <= tok_in.carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: rtl/move_to_front_encoder.sv
// Byte move-to-front encoder built as a systolic chain of list cells.
// Channels: symbols (sink) carries symbol and last; ranks (source) carries
// rank and last_out. A word moves on when valid and ready are both high.
// Each accepted symbol yields exactly one rank word, in order: the position
// the symbol held in the list, after which the symbol sits at the front.
// A word with last set puts the list back in identity order behind it.
// Symbols at or above ALPHABET_SIZE get rank ALPHABET_SIZE (mod 256) and
// leave the list as it was.
// The word visits every cell of the chain and is registered in each.
// Throughput is one symbol per cycle while ranks.ready is high or no
// result waits, since each cell sees the words in order.
// Reset loads the identity order into all cells at once and empties the
// chain; no clearing pass is needed.
// When the receiver holds ready low with a result waiting, the whole chain
// freezes and symbols.ready drops in the same cycle.
`timescale 1ns / 1ps
module move_to_front_encoder
  import mtf_pkg::*;
#(
  parameter int ALPHABET_SIZE = 256
) (
  input logic         clk,
  input logic         rst,
  mtf_in_if.sink      symbols,
  mtf_out_if.source   ranks
);

  mtf_token_t tok [ALPHABET_SIZE+1];
  logic       adv;
  logic       outside;

  assign adv     = !tok[ALPHABET_SIZE].valid || ranks.ready;
  assign outside = {1'b0, symbols.symbol} >= 9'(ALPHABET_SIZE);

  assign symbols.ready = adv;

  always_comb begin
    tok[0].valid  = symbols.valid;
    tok[0].symbol = symbols.symbol;
    // the front cell takes the symbol itself
    tok[0].carry  = symbols.symbol;
    // a symbol outside the alphabet never matches, so skip the shift
    tok[0].found  = outside;
    tok[0].rank   = outside ? RANK_W'(ALPHABET_SIZE) : '0;
    tok[0].last   = symbols.last;
  end

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    mtf_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign ranks.valid    = tok[ALPHABET_SIZE].valid;
  assign ranks.rank     = tok[ALPHABET_SIZE].rank;
  assign ranks.last_out = tok[ALPHABET_SIZE].last;

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    ranks.valid && !ranks.ready |-> !symbols.ready)
    else $error("input accepted while output stalled");

  a_in_alphabet_found : assert property (@(posedge clk) disable iff (rst)
    tok[ALPHABET_SIZE].valid && ({1'b0, tok[ALPHABET_SIZE].symbol} < 9'(ALPHABET_SIZE))
      |-> tok[ALPHABET_SIZE].found)
    else $error("symbol missing from list");

  a_outside_rank : assert property (@(posedge clk) disable iff (rst)
    tok[ALPHABET_SIZE].valid && ({1'b0, tok[ALPHABET_SIZE].symbol} >= 9'(ALPHABET_SIZE))
      |-> tok[ALPHABET_SIZE].rank == RANK_W'(ALPHABET_SIZE))
    else $error("wrong rank for symbol outside alphabet");

  a_empty_after_reset : assert property (@(posedge clk)
    $past(rst) |-> !ranks.valid)
    else $error("output valid right after reset");

endmodule

FILE: dv/tb_top.sv
// testbench for the byte move-to-front encoder: directed and random symbol runs
`timescale 1ns / 1ps
module tb_top;
  import mtf_pkg::*;

  localparam int ALPHABET    = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last;
  } rank_word_t;

  logic clk;
  logic rst;

  mtf_in_if  symbols_if ();
  mtf_out_if ranks_if ();

  move_to_front_encoder #(
    .ALPHABET_SIZE(ALPHABET)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .symbols(symbols_if),
    .ranks  (ranks_if)
  );

  // predicted list order and the rank words still owed by the block
  logic [SYM_W-1:0] mtf_list [ALPHABET];
  rank_word_t       rank_expected_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count = 0;
  int cycle_count = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void load_identity_list();
    for (int k = 0; k < ALPHABET; k++) begin
      mtf_list[k] = SYM_W'(k);
    end
  endfunction

  // rank of sym in the current order, then move it to the front; with fin set, go back to identity
  function automatic logic [RANK_W-1:0] mtf_encode(input logic [SYM_W-1:0] sym,
                                                   input logic fin);
    int pos;
    pos = ALPHABET;
    for (int k = 0; k < ALPHABET; k++) begin
      if (pos == ALPHABET && mtf_list[k] == sym) begin
        pos = k;
      end
    end
    if (pos < ALPHABET) begin
      for (int k = pos; k > 0; k--) begin
        mtf_list[k] = mtf_list[k-1];
      end
      mtf_list[0] = sym;
    end
    if (fin) begin
      load_identity_list();
    end
    return RANK_W'(pos);
  endfunction

  task automatic send_word(input logic [SYM_W-1:0] sym, input logic fin);
    rank_word_t exp_word;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      symbols_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    symbols_if.valid  <= 1'b1;
    symbols_if.symbol <= sym;
    symbols_if.last   <= fin;
    do @(posedge clk); while (!symbols_if.ready);
    exp_word.rank = mtf_encode(sym, fin);
    exp_word.last = fin;
    rank_expected_q.push_back(exp_word);
  endtask

  // hold the input side quiet until every owed rank word is out
  task automatic drain_ranks();
    symbols_if.valid <= 1'b0;
    while (rank_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(8'd1, 1'b0);
    send_word(8'd128, 1'b1);
  endtask

  task automatic test_repeats();
    send_word(8'd7, 1'b0);
    send_word(8'd7, 1'b0);
    send_word(8'd7, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd7, 1'b0);
    send_word(8'd9, 1'b0);
  endtask

  // the list must come back to identity after a word with last set
  task automatic test_sequence_restart();
    send_word(8'd200, 1'b0);
    send_word(8'd100, 1'b1);
    send_word(8'd200, 1'b0);
    send_word(8'd100, 1'b0);
    send_word(8'd42, 1'b1);
    send_word(8'd42, 1'b1);
    send_word(8'd255, 1'b1);
    send_word(8'd3, 1'b0);
  endtask

  task automatic test_random_sequences(input int n_items);
    int               sent;
    int               seq_len;
    int               mode;
    logic [SYM_W-1:0] sym;
    logic             fin;
    sent = 0;
    while (sent < n_items) begin
      seq_len = $urandom_range(48, 1);
      mode    = $urandom_range(3, 0);
      for (int i = 0; i < seq_len && sent < n_items; i++) begin
        case (mode)
          0: begin
            sym = SYM_W'($urandom_range(15, 0));
          end
          1: begin
            sym = SYM_W'($urandom_range(255, 0));
          end
          default: begin
            // mostly recent symbols, so ranks stay small and repeats are common
            if ($urandom_range(3, 0) != 0) begin
              sym = mtf_list[$urandom_range(7, 0)];
            end else begin
              sym = SYM_W'($urandom_range(255, 0));
            end
          end
        endcase
        fin = (i == seq_len - 1) ? ($urandom_range(7, 0) != 0)
                                 : ($urandom_range(63, 0) == 0);
        send_word(sym, fin);
        sent++;
      end
    end
  endtask

  // rank word checker and output-side stall generator
  always @(posedge clk) begin
    rank_word_t exp_word;
    if (!rst && ranks_if.valid && ranks_if.ready) begin
      if (rank_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected rank word: rank=%0d last_out=%0b",
                   ranks_if.rank, ranks_if.last_out);
        end
      end else begin
        exp_word = rank_expected_q.pop_front();
        if (ranks_if.rank !== exp_word.rank || ranks_if.last_out !== exp_word.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected rank=%0d last_out=%0b, got rank=%0d last_out=%0b",
                     exp_word.rank, exp_word.last, ranks_if.rank, ranks_if.last_out);
          end
        end
      end
    end
    ranks_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    symbols_if.valid  = 1'b0;
    symbols_if.symbol = '0;
    symbols_if.last   = 1'b0;
    send_idle_pct     = 12;
    recv_idle_pct     = 68;
    load_identity_list();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_repeats();
    test_sequence_restart();
    test_random_sequences(210);
    drain_ranks();

    send_idle_pct = 68;
    recv_idle_pct = 12;
    test_random_sequences(210);
    drain_ranks();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(210);
    drain_ranks();

    // the chain has one cell per symbol of the alphabet, so wait for any stray rank words
    repeat (ALPHABET + 32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
